// File: hdl/gns_pkg.sv
// Package for the Gower nearest-similarity block: widths, kind codes, states.
// No dependencies.
package gns_pkg;
   localparam int unsigned MaxRefRows = 1024;
   localparam int unsigned NumColumns = 4;
   localparam int unsigned CatColumns = 4;
   localparam int unsigned ColsMax = 4;
   localparam logic [16:0] OneQ16 = 17'd65536;

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic signed [31:0] num_a;
      logic signed [31:0] num_b;
      logic signed [31:0] num_c;
      logic signed [31:0] num_d;
      logic [15:0] cat_a;
      logic [15:0] cat_b;
      logic [15:0] cat_c;
      logic [15:0] cat_d;
      logic [7:0]  missing_mask;
   } req_type;

   typedef struct packed {
      logic [16:0] similarity;
      logic        comparable;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_TERM,
      ST_DIV,
      ST_ROW,
      ST_MEAN,
      ST_DONE
   } state_type;
endpackage

// File: hdl/gns_if.sv
// Valid/ready channel interface carrying one payload item.
// Depends on no package; the payload type is a parameter.
interface gns_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/gns_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module gns_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

// File: hdl/gower_nearest_similarity_top.sv
// Top level of the Gower nearest-similarity block: row store, ranges, query walk.
// Depends on gns_pkg, gns_if and gns_ram.
//
//  channel | direction | payload
//  req     | in        | kind, num_a..num_d, cat_a..cat_d, missing_mask
//  rsp     | out       | similarity, comparable
//
// A clear is done as it is accepted; a load into a store that is not full is accepted, then
// its store write and range update follow in ST_DONE. A query walks the stored rows one at a
// time: each row is fetched (ST_READ, ST_ROW), its column terms are worked in ST_TERM, and the
// shared bit-serial divider runs for each numeric term with a non-zero range and once more for
// the mean, cut short when nothing is comparable. Reset (synchronous) empties the store.
// The block is not ready while an item is at work or a result waits.
module gower_nearest_similarity_top #(
   parameter int unsigned MAX_REF_ROWS = gns_pkg::MaxRefRows
) (
   input logic clock,
   input logic reset,
   gns_if.sink   req,
   gns_if.source rsp
);
   import gns_pkg::*;

   localparam int unsigned AW = $clog2(MAX_REF_ROWS) > 0 ? $clog2(MAX_REF_ROWS) : 1;
   localparam int unsigned CW = $clog2(MAX_REF_ROWS + 1);
   // Iterations of the divider: one per bit of the 51-bit dividend.
   localparam int unsigned DIVW = 51;

   state_type state_ff, state_in;
   req_type   q_ff, q_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] row_ff, row_in;
   logic signed [31:0] min_ff [ColsMax], max_ff [ColsMax];
   logic signed [31:0] min_in [ColsMax], max_in [ColsMax];
   logic [2:0]  col_ff, col_in;
   logic [50:0] sum_ff, sum_in;
   logic [3:0]  n_ff, n_in;
   logic [16:0] best_ff, best_in;
   logic        any_ff, any_in;
   logic        rsp_valid_ff, rsp_valid_in;
   // divider
   logic [50:0] rem_ff, rem_in;
   logic [50:0] quo_ff, quo_in;
   logic [32:0] den_ff, den_in;
   logic [5:0]  step_ff, step_in;

   // store: numeric 128 bits, category 64 bits, mask 8 bits, one word per row
   logic        wr_en;
   logic [AW-1:0] ram_addr;
   logic [199:0] wr_word, rd_word;

   gns_ram #(.WIDTH(200), .DEPTH(MAX_REF_ROWS)) u_store (
      .clock(clock), .wr_en(wr_en), .addr(ram_addr),
      .wr_data(wr_word), .rd_data(rd_word)
   );

   assign wr_word = {q_ff.num_a, q_ff.num_b, q_ff.num_c, q_ff.num_d,
                     q_ff.cat_a, q_ff.cat_b, q_ff.cat_c, q_ff.cat_d, q_ff.missing_mask};

   logic signed [31:0] qnum [ColsMax];
   logic [15:0] qcat [ColsMax];
   assign qnum[0] = q_ff.num_a; assign qnum[1] = q_ff.num_b;
   assign qnum[2] = q_ff.num_c; assign qnum[3] = q_ff.num_d;
   assign qcat[0] = q_ff.cat_a; assign qcat[1] = q_ff.cat_b;
   assign qcat[2] = q_ff.cat_c; assign qcat[3] = q_ff.cat_d;

   // row held steady while its columns are worked through
   logic [199:0] row_word_ff, row_word_in;
   logic signed [31:0] hnum [ColsMax];
   logic [15:0] hcat [ColsMax];
   logic [7:0]  hmask;
   assign hnum[0] = row_word_ff[199:168]; assign hnum[1] = row_word_ff[167:136];
   assign hnum[2] = row_word_ff[135:104]; assign hnum[3] = row_word_ff[103:72];
   assign hcat[0] = row_word_ff[71:56];   assign hcat[1] = row_word_ff[55:40];
   assign hcat[2] = row_word_ff[39:24];   assign hcat[3] = row_word_ff[23:8];
   assign hmask   = row_word_ff[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < ColsMax; k++) begin
            min_ff[k] <= 32'sh7FFFFFFF;
            max_ff[k] <= 32'sh80000000;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
      end
      q_ff <= q_in; row_ff <= row_in; col_ff <= col_in; sum_ff <= sum_in;
      n_ff <= n_in; best_ff <= best_in; any_ff <= any_in;
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; step_ff <= step_in;
      row_word_ff <= row_word_in;
   end

   logic [1:0]  cidx;
   logic [32:0] range_c, diff_c;
   logic signed [32:0] dsub;
   logic [51:0] trial;
   logic        skip_c;
   logic [16:0] sim_c;

   always_comb begin
      state_in = state_ff; q_in = q_ff; count_in = count_ff; row_in = row_ff;
      min_in = min_ff; max_in = max_ff; col_in = col_ff; sum_in = sum_ff;
      n_in = n_ff; best_in = best_ff; any_in = any_ff; rsp_valid_in = rsp_valid_ff;
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; step_in = step_ff;
      row_word_in = row_word_ff;
      wr_en = 1'b0; ram_addr = row_ff[AW-1:0];
      req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
      rsp.valid = rsp_valid_ff;
      rsp.payload.similarity = best_ff;
      rsp.payload.comparable = any_ff;
      if (rsp.valid && rsp.ready) rsp_valid_in = 1'b0;

      cidx    = col_ff[1:0];
      range_c = (max_ff[cidx] > min_ff[cidx]) ?
                33'({max_ff[cidx][31], max_ff[cidx]} - {min_ff[cidx][31], min_ff[cidx]}) : '0;
      dsub    = {hnum[cidx][31], hnum[cidx]} - {qnum[cidx][31], qnum[cidx]};
      diff_c  = dsub[32] ? 33'(-dsub) : 33'(dsub);
      skip_c  = col_ff[2] ? (((q_ff.missing_mask | hmask) >> (3'd4 + {1'b0, cidx})) & 8'd1) != 0
                          : (((q_ff.missing_mask | hmask) >> cidx) & 8'd1) != 0;
      trial   = {rem_ff, quo_ff[50]} - {19'd0, den_ff};
      sim_c   = (quo_ff[50:0] >= 51'(OneQ16)) ? 17'd0 : 17'(OneQ16 - quo_ff[16:0]);

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               q_in = req.payload;
               unique case (kind_type'(req.payload.kind))
                  KIND_CLEAR: begin
                     count_in = '0;
                     for (int k = 0; k < ColsMax; k++) begin
                        min_in[k] = 32'sh7FFFFFFF;
                        max_in[k] = 32'sh80000000;
                     end
                  end
                  KIND_LOAD:  state_in = (count_ff < CW'(MAX_REF_ROWS)) ? ST_DONE : ST_IDLE;
                  KIND_QUERY: begin
                     row_in = '0; best_in = '0; any_in = 1'b0;
                     state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_DONE: begin // load write and min/max update
            wr_en = 1'b1; ram_addr = count_ff[AW-1:0];
            for (int k = 0; k < NumColumns; k++) begin
               if (!q_ff.missing_mask[k]) begin
                  if (qnum[k] < min_ff[k]) min_in[k] = qnum[k];
                  if (qnum[k] > max_ff[k]) max_in[k] = qnum[k];
               end
            end
            count_in = count_ff + 1'b1;
            state_in = ST_IDLE;
         end
         ST_READ: begin
            if (row_ff >= count_ff) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin // read data now valid
            row_word_in = rd_word;
            col_in = '0; sum_in = '0; n_in = '0;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            if (!skip_c && ((col_ff[2] && {1'b0, cidx} < 3'(CatColumns)) ||
                            (!col_ff[2] && {1'b0, cidx} < 3'(NumColumns)))) begin
               n_in = n_ff + 1'b1;
               if (col_ff[2]) begin
                  if (hcat[cidx] != qcat[cidx]) sum_in = sum_ff + 51'(OneQ16);
               end else if (range_c != 0) begin
                  rem_in = '0; quo_in = {2'd0, diff_c, 16'd0};
                  den_in = range_c; step_in = '0;
                  state_in = ST_DIV;
               end
            end
            col_in = col_ff + 1'b1;
            if (col_ff == 3'd7 && state_in == ST_TERM) begin
               rem_in = '0; quo_in = sum_ff + ((hcat[3] != qcat[3] && !skip_c
                                && CatColumns == 4) ? 51'(OneQ16) : 51'd0);
               den_in = {29'd0, n_in}; step_in = '0;
               state_in = ST_MEAN;
            end
         end
         ST_DIV, ST_MEAN: begin // shared restoring divider, one bit a cycle
            if (trial[51]) rem_in = {rem_ff[49:0], quo_ff[50]};
            else           rem_in = trial[50:0];
            quo_in = {quo_ff[49:0], ~trial[51]};
            step_in = step_ff + 1'b1;
            if (step_ff == 6'(DIVW)) begin
               rem_in = rem_ff; quo_in = quo_ff;
               if (state_ff == ST_DIV) begin
                  sum_in = sum_ff + quo_ff;
                  state_in = ST_TERM;
               end else begin
                  if (n_ff != 0) begin
                     any_in = 1'b1;
                     if (sim_c > best_ff) best_in = sim_c;
                  end
                  row_in = row_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
            if (step_ff == 6'd0 && state_ff == ST_MEAN && n_ff == 0) begin
               step_in = 6'(DIVW);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_REF_ROWS)) else $error("row count beyond capacity");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("ready while busy");
   a_sim_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (best_ff <= OneQ16)) else $error("similarity above one");
   a_zero_when_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !any_ff) |-> (best_ff == 17'd0)) else $error("similarity without pair");
`endif
endmodule
